[src/radial_profile_histogram_defines.svh]
// ----------------------------------------------------------------------------
// radial_profile_histogram_defines.svh
// Assertion macros used by the radial profile histogram RTL.
// ----------------------------------------------------------------------------
`ifndef RADIAL_PROFILE_HISTOGRAM_DEFINES_SVH
`define RADIAL_PROFILE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rph assertion failed");

// Next-cycle implication, disabled while in reset.
`define RPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rph assertion failed");

`endif

[src/rph_pkg.sv]
// ----------------------------------------------------------------------------
// rph_pkg
// Widths, codes and defaults of the radial profile histogram.
// ----------------------------------------------------------------------------
package rph_pkg;

  localparam int DEF_MAX_SIDE   = 256;
  localparam int DEF_NUM_BINS   = 512;
  localparam int DEF_PIXEL_BITS = 32;

  localparam int CMD_W     = 2;
  localparam int PIX_W     = 32;
  localparam int IDX_W     = 9;
  localparam int CFG_REG_W = 9;
  localparam int ASPECT_W  = 11;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam int SUM_W  = 49;
  localparam int CNT_W  = 17;
  localparam int MEAN_W = 32;
  localparam int MM_W   = 32;
  localparam int WSUM_W = 44;
  localparam int WCNT_W = 13;
  localparam int HB_W   = 9;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 232;

  localparam int FRAC_BITS  = 8;
  localparam int ROUND_HALF = 128;   // 0.5 in Q8

  localparam logic [CFG_REG_W-1:0] RST_SIDE   = 9'd256;
  localparam logic [ASPECT_W-1:0]  RST_ASPECT = 11'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ASPECT = 2'd2
  } reg_idx_t;

  localparam logic KIND_BIN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

[src/rph_bin_store.sv]
// ----------------------------------------------------------------------------
// rph_bin_store
// Single-port-write, registered-read memory holding bin sum and count.
// ----------------------------------------------------------------------------
module rph_bin_store #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 66
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/rph_isqrt.sv]
// ----------------------------------------------------------------------------
// rph_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rph_isqrt #(
  parameter int ROOT_W = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_r;
  logic [ROOT_W:0]     rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [STEP_W-1:0]   step_r;
  logic                busy_r;
  logic                done_r;

  logic [ROOT_W+2:0] rem_t;
  logic [ROOT_W+2:0] trial;
  logic              ge;

  always_comb begin
    rem_t = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    ge    = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[2*ROOT_W-3:0], 2'b00};
        rem_r  <= ge ? (ROOT_W+1)'(rem_t - trial) : (ROOT_W+1)'(rem_t);
        root_r <= {root_r[ROOT_W-2:0], ge};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/rph_divider.sv]
// ----------------------------------------------------------------------------
// rph_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rph_divider #(
  parameter int DVD_W = 49,
  parameter int DVS_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0] rem_t;
  logic           ge;

  always_comb begin
    rem_t = {rem_r, q_r[DVD_W-1]};
    ge    = rem_t >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? DVS_W'(rem_t - {1'b0, dvs_r}) : DVS_W'(rem_t);
        q_r    <= {q_r[DVD_W-2:0], ge};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[src/radial_profile_histogram.sv]
// ----------------------------------------------------------------------------
// radial_profile_histogram
// Radial (azimuthal) profile of a centered power spectrum with frame summary.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : stream of commands. tuser = cmd (pixel, read bin, clear).
//           tdata = pixel_value, bin_index. Pixels arrive in raster order.
//   out_* : result stream. tuser = report kind (bin report / frame summary).
//   cfg_* : register writes (width, height, aspect), taken every cycle;
//           write only while the block is idle.
// Transaction flow (one transaction at a time):
//   pixel  : paced by the bit-serial square root between one accepted
//            transaction and the next; this includes the bin
//            read-modify-write. The last pixel of a frame also passes through
//            the emit state to load its summary into the output register.
//   read   : paced by the bit-serial divider; an empty or out-of-range bin
//            skips the divider.
//   clear  : sweeps every address of the bin memory.
// Reset: runs the same clearing pass; in_tready stays low until it is
//   done. Registers return to 256 / 256 / 1.0.
// Output stall: results sit in an output register; the next command is
//   still taken and only waits if it must deliver a result itself.
// ----------------------------------------------------------------------------
`include "radial_profile_histogram_defines.svh"

module radial_profile_histogram #(
  parameter int MAX_SIDE   = rph_pkg::DEF_MAX_SIDE,
  parameter int NUM_BINS   = rph_pkg::DEF_NUM_BINS,
  parameter int PIXEL_BITS = rph_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rph_pkg::IN_TDATA_W-1:0]    in_tdata,   // pixel_value, bin_index
  input  logic [rph_pkg::CMD_W-1:0]         in_tuser,   // cmd
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rph_pkg::OUT_TDATA_W-1:0]   out_tdata,  // bin_sum, bin_count,
                                                        // bin_mean, frame_min,
                                                        // frame_max, window_sum,
                                                        // window_count,
                                                        // highest_bin
  output logic                              out_tuser,  // report_kind
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rph_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rph_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import rph_pkg::*;

  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int EXT_W  = SIDE_W + 3;
  localparam int ROOT_W = POS_W + 12;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SY_W   = POS_W + ASPECT_W;
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int DATA_W = SUM_W + CNT_W;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_SCALE  = 9'b000000100,
    ST_SQUARE = 9'b000001000,
    ST_SQRT   = 9'b000010000,
    ST_FETCH  = 9'b000100000,
    ST_UPDATE = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  // ---- registers --------------------------------------------------------
  state_t                 state_r, state_nxt;
  logic [BIN_W-1:0]       clr_idx_r, clr_idx_nxt;
  logic [CFG_REG_W-1:0]   width_r, height_r;
  logic [ASPECT_W-1:0]    aspect_r;

  // frame trackers
  logic [POS_W-1:0]       col_r, col_nxt;
  logic [POS_W-1:0]       row_r, row_nxt;
  logic [BIN_W-1:0]       top_bin_r, top_bin_nxt;
  logic [PIXEL_BITS-1:0]  min_r, min_nxt;
  logic [PIXEL_BITS-1:0]  max_r, max_nxt;
  logic [WSUM_W-1:0]      wsum_r, wsum_nxt;
  logic [WCNT_W-1:0]      wcnt_r, wcnt_nxt;

  // per-transaction working registers
  logic                   is_pixel_r, is_pixel_nxt;
  logic                   frame_end_r, frame_end_nxt;
  logic [POS_W-1:0]       ax_r, ax_nxt;
  logic [POS_W-1:0]       ay_r, ay_nxt;
  logic [SY_W-1:0]        sy_r, sy_nxt;
  logic [PIXEL_BITS-1:0]  pix_r, pix_nxt;
  logic [BIN_W-1:0]       bin_r, bin_nxt;
  logic [SUM_W-1:0]       res_sum_r, res_sum_nxt;
  logic [CNT_W-1:0]       res_cnt_r, res_cnt_nxt;
  logic [MEAN_W-1:0]      res_mean_r, res_mean_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [SUM_W-1:0]       o_sum_r, o_sum_nxt;
  logic [CNT_W-1:0]       o_cnt_r, o_cnt_nxt;
  logic [MEAN_W-1:0]      o_mean_r, o_mean_nxt;
  logic [MM_W-1:0]        o_min_r, o_min_nxt;
  logic [MM_W-1:0]        o_max_r, o_max_nxt;
  logic [WSUM_W-1:0]      o_wsum_r, o_wsum_nxt;
  logic [WCNT_W-1:0]      o_wcnt_r, o_wcnt_nxt;
  logic [HB_W-1:0]        o_hb_r, o_hb_nxt;

  // ---- datapath wires ---------------------------------------------------
  logic                   in_acc;
  logic [CMD_W-1:0]       in_cmd;
  logic [PIX_W-1:0]       in_pix;
  logic [IDX_W-1:0]       in_idx;

  logic [SIDE_W-1:0]      nx, ny;
  logic [EXT_W-1:0]       nx_e, ny_e, xm_e, ym_e, ix_e, iy_e;
  logic [EXT_W-1:0]       ax_e, ay_e;
  logic [EXT_W-1:0]       wx_lo, wx_hi, wy_lo, wy_hi;
  logic                   row_end, frame_end;
  logic                   in_window, off_centre, first_pix;
  logic [PIXEL_BITS-1:0]  acc_pix;
  logic [WSUM_W:0]        wsum_add;
  logic [WCNT_W:0]        wcnt_add;

  logic                   sqrt_start, sqrt_done;
  logic [2*POS_W-1:0]     ax_sq;
  logic [2*SY_W-1:0]      sy_sq;
  logic [RAD_W-1:0]       radicand;
  logic [ROOT_W-1:0]      root;
  logic [ROOT_W:0]        rounded;
  logic [31:0]            bin_wide;

  logic                   div_start, div_done;
  logic [SUM_W-1:0]       quotient;

  logic                   mem_we, mem_re;
  logic [BIN_W-1:0]       mem_waddr;
  logic [DATA_W-1:0]      mem_wdata, mem_rdata;
  logic [SUM_W-1:0]       rd_sum;
  logic [CNT_W-1:0]       rd_cnt;
  logic [SUM_W:0]         sum_add;
  logic [CNT_W:0]         cnt_add;
  logic [SUM_W-1:0]       new_sum;
  logic [CNT_W-1:0]       new_cnt;
  logic                   out_free;

  assign in_cmd = in_tuser;
  assign in_pix = in_tdata[PIX_W-1:0];
  assign in_idx = in_tdata[PIX_W +: IDX_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // ---- configuration ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_SIDE;
      height_r <= RST_SIDE;
      aspect_r <= RST_ASPECT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_data[CFG_REG_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[CFG_REG_W-1:0];
        REG_ASPECT: aspect_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame size clamped to 2..MAX_SIDE.
  always_comb begin
    logic [31:0] w32, h32;
    w32 = 32'(width_r);
    h32 = 32'(height_r);
    nx = (w32 < 32'd2) ? SIDE_W'(2) : (w32 > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(w32);
    ny = (h32 < 32'd2) ? SIDE_W'(2) : (h32 > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(h32);
  end

  // ---- position geometry ------------------------------------------------
  always_comb begin
    nx_e  = EXT_W'(nx);
    ny_e  = EXT_W'(ny);
    xm_e  = nx_e >> 1;
    ym_e  = ny_e >> 1;
    ix_e  = EXT_W'(col_r);
    iy_e  = EXT_W'(row_r);
    ax_e  = (ix_e >= xm_e) ? ix_e - xm_e : xm_e - ix_e;
    ay_e  = (iy_e >= ym_e) ? iy_e - ym_e : ym_e - iy_e;
    // window bounds 3n/8 and 5n/8, exclusive
    wx_lo = ((nx_e << 1) + nx_e) >> 3;
    wx_hi = ((nx_e << 2) + nx_e) >> 3;
    wy_lo = ((ny_e << 1) + ny_e) >> 3;
    wy_hi = ((ny_e << 2) + ny_e) >> 3;
    in_window  = (ix_e > wx_lo) && (ix_e < wx_hi) && (iy_e > wy_lo) && (iy_e < wy_hi);
    first_pix  = (col_r == '0) && (row_r == '0);
    off_centre = (ix_e != xm_e) && (iy_e != ym_e);
    row_end    = (ix_e + 1'b1) >= nx_e;
    frame_end  = row_end && ((iy_e + 1'b1) >= ny_e);
    acc_pix    = in_pix[PIXEL_BITS-1:0];
    wsum_add   = {1'b0, wsum_r} + (WSUM_W+1)'(acc_pix);
    wcnt_add   = {1'b0, wcnt_r} + 1'b1;
  end

  // ---- bin arithmetic ---------------------------------------------------
  always_comb begin
    ax_sq    = ax_r * ax_r;
    sy_sq    = sy_r * sy_r;
    radicand = (RAD_W'(ax_sq) << 16) + RAD_W'(sy_sq);
    rounded  = (ROOT_W+1)'(root) + (ROOT_W+1)'(ROUND_HALF);
    bin_wide = 32'(rounded >> FRAC_BITS);
  end

  assign rd_sum  = mem_rdata[DATA_W-1:CNT_W];
  assign rd_cnt  = mem_rdata[CNT_W-1:0];
  assign sum_add = {1'b0, rd_sum} + (SUM_W+1)'(pix_r);
  assign cnt_add = {1'b0, rd_cnt} + 1'b1;
  assign new_sum = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign new_cnt = cnt_add[CNT_W] ? {CNT_W{1'b1}} : cnt_add[CNT_W-1:0];

  assign sqrt_start = (state_r == ST_SQUARE);
  assign mem_re     = (state_r == ST_FETCH);
  assign mem_we     = (state_r == ST_CLEAR) || ((state_r == ST_UPDATE) && is_pixel_r);
  assign mem_waddr  = (state_r == ST_CLEAR) ? clr_idx_r : bin_r;
  assign mem_wdata  = (state_r == ST_CLEAR) ? '0 : {new_sum, new_cnt};
  assign div_start  = (state_r == ST_UPDATE) && !is_pixel_r && (rd_cnt != '0);

  // ---- control ----------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    top_bin_nxt   = top_bin_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    wsum_nxt      = wsum_r;
    wcnt_nxt      = wcnt_r;
    is_pixel_nxt  = is_pixel_r;
    frame_end_nxt = frame_end_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    sy_nxt        = sy_r;
    pix_nxt       = pix_r;
    bin_nxt       = bin_r;
    res_sum_nxt   = res_sum_r;
    res_cnt_nxt   = res_cnt_r;
    res_mean_nxt  = res_mean_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    o_sum_nxt     = o_sum_r;
    o_cnt_nxt     = o_cnt_r;
    o_mean_nxt    = o_mean_r;
    o_min_nxt     = o_min_r;
    o_max_nxt     = o_max_r;
    o_wsum_nxt    = o_wsum_r;
    o_wcnt_nxt    = o_wcnt_r;
    o_hb_nxt      = o_hb_r;

    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == BIN_W'(NUM_BINS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_PIXEL: begin
              is_pixel_nxt  = 1'b1;
              frame_end_nxt = frame_end;
              ax_nxt        = POS_W'(ax_e);
              ay_nxt        = POS_W'(ay_e);
              pix_nxt       = acc_pix;
              if (first_pix) begin
                min_nxt = acc_pix;
                max_nxt = acc_pix;
              end else if (off_centre) begin
                if (acc_pix < min_r) min_nxt = acc_pix;
                if (acc_pix > max_r) max_nxt = acc_pix;
              end
              if (in_window) begin
                wsum_nxt = wsum_add[WSUM_W] ? {WSUM_W{1'b1}} : wsum_add[WSUM_W-1:0];
                wcnt_nxt = wcnt_add[WCNT_W] ? {WCNT_W{1'b1}} : wcnt_add[WCNT_W-1:0];
              end
              if (!row_end) begin
                col_nxt = col_r + 1'b1;
              end else if (!frame_end) begin
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
              end else begin
                col_nxt = '0;
                row_nxt = '0;
              end
              state_nxt = ST_SCALE;
            end
            CMD_READ: begin
              is_pixel_nxt = 1'b0;
              if (32'(in_idx) < NUM_BINS) begin
                bin_nxt   = BIN_W'(in_idx);
                state_nxt = ST_FETCH;
              end else begin
                res_sum_nxt  = '0;
                res_cnt_nxt  = '0;
                res_mean_nxt = '0;
                state_nxt    = ST_EMIT;
              end
            end
            CMD_CLEAR: begin
              col_nxt     = '0;
              row_nxt     = '0;
              top_bin_nxt = '0;
              min_nxt     = '0;
              max_nxt     = '0;
              wsum_nxt    = '0;
              wcnt_nxt    = '0;
              clr_idx_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end

      ST_SCALE: begin
        sy_nxt    = SY_W'(ay_r) * SY_W'(aspect_r);
        state_nxt = ST_SQUARE;
      end

      ST_SQUARE: begin
        state_nxt = ST_SQRT;
      end

      ST_SQRT: begin
        if (sqrt_done) begin
          bin_nxt   = (bin_wide > NUM_BINS - 1) ? BIN_W'(NUM_BINS - 1) : BIN_W'(bin_wide);
          state_nxt = ST_FETCH;
        end
      end

      ST_FETCH: begin
        state_nxt = ST_UPDATE;
      end

      ST_UPDATE: begin
        if (is_pixel_r) begin
          if (bin_r > top_bin_r) top_bin_nxt = bin_r;
          state_nxt = frame_end_r ? ST_EMIT : ST_IDLE;
        end else begin
          res_sum_nxt  = rd_sum;
          res_cnt_nxt  = rd_cnt;
          res_mean_nxt = '0;
          state_nxt    = (rd_cnt != '0) ? ST_DIV : ST_EMIT;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          res_mean_nxt = (quotient[SUM_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}}
                                                          : quotient[MEAN_W-1:0];
          state_nxt    = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (is_pixel_r) begin
            out_kind_nxt = KIND_SUMMARY;
            o_sum_nxt    = '0;
            o_cnt_nxt    = '0;
            o_mean_nxt   = '0;
            o_min_nxt    = MM_W'(min_r);
            o_max_nxt    = MM_W'(max_r);
            o_wsum_nxt   = wsum_r;
            o_wcnt_nxt   = wcnt_r;
            o_hb_nxt     = HB_W'(top_bin_r);
            // frame trackers restart for the next frame
            top_bin_nxt  = '0;
            min_nxt      = '0;
            max_nxt      = '0;
            wsum_nxt     = '0;
            wcnt_nxt     = '0;
          end else begin
            out_kind_nxt = KIND_BIN;
            o_sum_nxt    = res_sum_r;
            o_cnt_nxt    = res_cnt_r;
            o_mean_nxt   = res_mean_r;
            o_min_nxt    = '0;
            o_max_nxt    = '0;
            o_wsum_nxt   = '0;
            o_wcnt_nxt   = '0;
            o_hb_nxt     = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      top_bin_r   <= '0;
      min_r       <= '0;
      max_r       <= '0;
      wsum_r      <= '0;
      wcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      top_bin_r   <= top_bin_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      wsum_r      <= wsum_nxt;
      wcnt_r      <= wcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_pixel_r  <= is_pixel_nxt;
    frame_end_r <= frame_end_nxt;
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    sy_r        <= sy_nxt;
    pix_r       <= pix_nxt;
    bin_r       <= bin_nxt;
    res_sum_r   <= res_sum_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_mean_r  <= res_mean_nxt;
    out_kind_r  <= out_kind_nxt;
    o_sum_r     <= o_sum_nxt;
    o_cnt_r     <= o_cnt_nxt;
    o_mean_r    <= o_mean_nxt;
    o_min_r     <= o_min_nxt;
    o_max_r     <= o_max_nxt;
    o_wsum_r    <= o_wsum_nxt;
    o_wcnt_r    <= o_wcnt_nxt;
    o_hb_r      <= o_hb_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0000, o_hb_r, o_wcnt_r, o_wsum_r, o_max_r, o_min_r,
                       o_mean_r, o_cnt_r, o_sum_r};

  // ---- submodules -------------------------------------------------------
  rph_bin_store #(
    .DEPTH  (NUM_BINS),
    .ADDR_W (BIN_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (bin_r),
    .rdata (mem_rdata)
  );

  rph_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  rph_divider #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_sum),
    .divisor  (rd_cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---- assertions -------------------------------------------------------
  `RPH_ASSERT_IMP(a_no_take_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_tready)
  `RPH_ASSERT_IMP(a_write_phase, clk, rst_n, mem_we, (state_r == ST_CLEAR) || (state_r == ST_UPDATE))
  `RPH_ASSERT_IMP(a_sqrt_owned, clk, rst_n, sqrt_done, state_r == ST_SQRT)
  `RPH_ASSERT_IMP(a_div_owned, clk, rst_n, div_done, state_r == ST_DIV)
  `RPH_ASSERT_NXT(a_emit_lands, clk, rst_n, (state_r == ST_EMIT) && out_free, out_valid_r && (state_r == ST_IDLE))

endmodule
